// ===== hw/rtl/vrt_pkg.sv =====
// Shared types, constants and codes of the voxel ray traversal core.
`default_nettype none

package vrt_pkg;

  // Grid and number format
  localparam int GRID_CHUNKS_DEF = 16;
  localparam int FRAC_BITS       = 16;
  localparam int POS_W           = 24;
  localparam int DIR_W           = 18;
  localparam int VOX_W           = 6;
  localparam int OPEN_W          = 8;
  localparam int CUR_W           = 10;
  localparam int WORD_W          = 64;
  localparam int ENTRY_W         = WORD_W + 1;

  // Shared arithmetic unit widths
  localparam int AD_W    = DIR_W;
  localparam int NUM_W   = 2 * FRAC_BITS + 1;
  localparam int DELTA_W = NUM_W;
  localparam int T_W     = 48;
  localparam int P_W     = T_W + 1 + AD_W;
  localparam int CNT_W   = 7;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  // Function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_CAST  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  typedef struct packed {
    logic             start;
    logic             op_mul;
    logic [T_W-1:0]   opa;
    logic [AD_W-1:0]  opb;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [P_W-1:0]   res;
  } arith_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vrt_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vrt_arith.sv =====
// Shared iterative unit: restoring divider and shift-add multiplier.
`default_nettype none

module vrt_arith (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vrt_pkg::arith_req_t req_i,
  output vrt_pkg::arith_rsp_t      rsp_o
);

  localparam int AD_W  = vrt_pkg::AD_W;
  localparam int T_W   = vrt_pkg::T_W;
  localparam int P_W   = vrt_pkg::P_W;
  localparam int NUM_W = vrt_pkg::NUM_W;
  localparam int CNT_W = vrt_pkg::CNT_W;

  logic             run_q, mul_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [P_W-1:0]   acc_q;
  logic [AD_W-1:0]  rem_q;
  logic [T_W-1:0]   opa_q;
  logic [AD_W-1:0]  opb_q;

  logic [T_W:0]     hi, addend, sum;
  logic [P_W-1:0]   mul_nxt, div_nxt;
  logic [AD_W:0]    rsh, rdiff;
  logic             ge;
  logic [AD_W-1:0]  rem_nxt;

  // One multiplier bit per cycle: add, then shift right
  assign hi      = acc_q[P_W-1:AD_W];
  assign addend  = acc_q[0] ? {1'b0, opa_q} : '0;
  assign sum     = hi + addend;
  assign mul_nxt = {1'b0, sum, acc_q[AD_W-1:1]};

  // One quotient bit per cycle: shift in, compare, subtract
  assign rsh     = {rem_q, acc_q[NUM_W-1]};
  assign ge      = rsh >= {1'b0, opb_q};
  assign rdiff   = rsh - {1'b0, opb_q};
  assign rem_nxt = ge ? rdiff[AD_W-1:0] : rsh[AD_W-1:0];
  assign div_nxt = {acc_q[P_W-2:0], ge};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.op_mul ? CNT_W'(AD_W) : CNT_W'(NUM_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and working registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mul_q <= req_i.op_mul;
      opa_q <= req_i.opa;
      opb_q <= req_i.opb;
      rem_q <= '0;
      acc_q <= req_i.op_mul ? P_W'(req_i.opb) : P_W'(req_i.opa);
    end else if (run_q) begin
      acc_q <= mul_q ? mul_nxt : div_nxt;
      rem_q <= rem_nxt;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/voxel_ray_traversal_core.sv =====
// Top level: voxel map, touched-chunk box and ray walk sequencer.
//
//  channel   | handshake                | word
//  ----------+--------------------------+---------------------------------------
//  command   | start_i, busy_o          | func_i, vox_*_i, origin_*_i, dir_*_i
//  result    | done_o (one-cycle strobe)| hit_o, hit_*_o, open_*_o
//
// A command is taken when start_i is high and busy_o low. Reset, and every clear
// command, start a sweep that zeroes all 2^(3*ceil(log2(GRID_CHUNKS))) map RAM
// entries (4096 at the default size) with busy_o high. A write reads the map word
// and then writes it back. A cast runs a reciprocal setup on the shared divider for
// each axis with a nonzero direction (two divisions of 33 steps each), reads and
// checks each voxel visited, and on a hit runs one multiplication per axis on the
// shared multiplier. The result is shown for one cycle and cannot be held off.
`default_nettype none

module voxel_ray_traversal_core #(
  parameter int GRID_CHUNKS = vrt_pkg::GRID_CHUNKS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         func_i,
  input  wire logic [vrt_pkg::VOX_W-1:0]          vox_x_i,
  input  wire logic [vrt_pkg::VOX_W-1:0]          vox_y_i,
  input  wire logic [vrt_pkg::VOX_W-1:0]          vox_z_i,
  input  wire logic                               vox_on_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0]   origin_x_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0]   origin_y_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0]   origin_z_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0]   dir_x_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0]   dir_y_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0]   dir_z_i,
  output logic                                    done_o,
  output logic                                    hit_o,
  output logic signed [vrt_pkg::POS_W-1:0]        hit_x_o,
  output logic signed [vrt_pkg::POS_W-1:0]        hit_y_o,
  output logic signed [vrt_pkg::POS_W-1:0]        hit_z_o,
  output logic signed [vrt_pkg::OPEN_W-1:0]       open_x_o,
  output logic signed [vrt_pkg::OPEN_W-1:0]       open_y_o,
  output logic signed [vrt_pkg::OPEN_W-1:0]       open_z_o
);

  localparam int F       = vrt_pkg::FRAC_BITS;
  localparam int POS_W   = vrt_pkg::POS_W;
  localparam int DIR_W   = vrt_pkg::DIR_W;
  localparam int CUR_W   = vrt_pkg::CUR_W;
  localparam int AD_W    = vrt_pkg::AD_W;
  localparam int NUM_W   = vrt_pkg::NUM_W;
  localparam int DELTA_W = vrt_pkg::DELTA_W;
  localparam int T_W     = vrt_pkg::T_W;
  localparam int P_W     = vrt_pkg::P_W;
  localparam int WORD_W  = vrt_pkg::WORD_W;
  localparam int ENTRY_W = vrt_pkg::ENTRY_W;
  localparam int OPEN_W  = vrt_pkg::OPEN_W;
  localparam int CW      = (GRID_CHUNKS > 1) ? $clog2(GRID_CHUNKS) : 1;
  localparam int ADDR_W  = 3 * CW;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int GRID_VOX = 4 * GRID_CHUNKS;
  localparam int SW      = P_W - F + 2;

  localparam logic signed [CUR_W-1:0] VOX_LIM  = CUR_W'(GRID_VOX);
  localparam logic [8:0]              WR_LIM   = 9'(GRID_VOX);
  localparam logic [CW-1:0]           BOX_TOP  = CW'(GRID_CHUNKS - 1);

  // Sequencer states
  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_WR_RD    = 4'd2;
  localparam logic [3:0] S_WR_WB    = 4'd3;
  localparam logic [3:0] S_SET      = 4'd4;
  localparam logic [3:0] S_DIV_DEL  = 4'd5;
  localparam logic [3:0] S_DIV_TM   = 4'd6;
  localparam logic [3:0] S_STEP_RD  = 4'd7;
  localparam logic [3:0] S_STEP_CHK = 4'd8;
  localparam logic [3:0] S_EXIT     = 4'd9;
  localparam logic [3:0] S_MUL_GO   = 4'd10;
  localparam logic [3:0] S_MUL_W    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0]              state_q, state_d;
  logic [ADDR_W-1:0]       clr_q;
  logic [1:0]              ax_q, m_q;
  logic [CW-1:0]           bmin_q [3];
  logic [CW-1:0]           bmax_q [3];
  logic                    box_ne_q;

  logic signed [POS_W-1:0] org_q  [3];
  logic [AD_W-1:0]         ad_q   [3];
  logic [2:0]              neg_q;
  logic signed [CUR_W-1:0] cur_q  [3];
  logic signed [CUR_W-1:0] open_q [3];
  logic [DELTA_W-1:0]      delta_q [3];
  logic [T_W-1:0]          tmax_q [3];
  logic [T_W-1:0]          t_q;
  logic signed [POS_W-1:0] pos_q  [3];
  logic                    hit_q;
  logic [vrt_pkg::VOX_W-1:0] wx_q, wy_q, wz_q;
  logic                    won_q;

  vrt_pkg::arith_req_t     areq;
  vrt_pkg::arith_rsp_t     arsp;

  logic                    accept;
  logic [AD_W-1:0]         ad_ax;
  logic signed [POS_W-1:0] org_ax;
  logic [F-1:0]            frac_ax;
  logic [F:0]              dist_ax;
  logic                    last_ax, all_zero;
  logic [2:0]              in_grid_v, oob_v;
  logic                    in_grid, oob, occupied;
  logic [ADDR_W-1:0]       cur_addr, wr_addr, ram_addr;
  logic [5:0]              cur_bit, wr_bit;
  logic                    ram_we;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic [WORD_W-1:0]       old_word, wr_mask, new_word;
  logic [1:0]              m01, m_sel;
  logic [7:0]              wxe, wye, wze;
  logic [CW-1:0]           wch [3];
  logic [P_W-F-1:0]        mag;
  logic signed [SW-1:0]    p_wide, o_wide, m_wide;
  logic signed [POS_W-1:0] p_sat;

  assign accept = start_i && (state_q == S_IDLE);

  // Per-axis operands of the current setup or multiply axis
  assign ad_ax   = ad_q[ax_q];
  assign org_ax  = org_q[ax_q];
  assign frac_ax = org_ax[F-1:0];
  always_comb begin
    if (neg_q[ax_q]) begin
      dist_ax = (frac_ax == '0) ? {1'b1, {F{1'b0}}} : {1'b0, frac_ax};
    end else begin
      dist_ax = {1'b1, {F{1'b0}}} - {1'b0, frac_ax};
    end
  end
  assign last_ax  = (ax_q == 2'd2);
  assign all_zero = (ad_q[0] == '0) && (ad_q[1] == '0) && (ad_q[2] == '0);

  // Shared unit requests
  always_comb begin
    areq.start  = 1'b0;
    areq.op_mul = 1'b0;
    areq.opa    = '0;
    areq.opb    = ad_ax;
    case (state_q)
      S_SET: begin
        areq.start = (ad_ax != '0);
        areq.opa   = T_W'({1'b1, {(2 * F){1'b0}}});
      end
      S_DIV_DEL: begin
        areq.start = arsp.done;
        areq.opa   = T_W'({dist_ax, {F{1'b0}}});
      end
      S_MUL_GO: begin
        areq.start  = 1'b1;
        areq.op_mul = 1'b1;
        areq.opa    = t_q;
      end
      default: ;
    endcase
  end

  vrt_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .rsp_o  (arsp)
  );

  // Map address of the walk position and its box test
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_grid_v[i] = (cur_q[i] >= 0) && (cur_q[i] < VOX_LIM);
      if (neg_q[i]) begin
        oob_v[i] = cur_q[i] < $signed({{(CUR_W - CW - 2){1'b0}}, bmin_q[i], 2'b00});
      end else begin
        oob_v[i] = cur_q[i] > $signed({{(CUR_W - CW - 2){1'b0}}, bmax_q[i], 2'b11});
      end
    end
  end
  assign in_grid  = &in_grid_v;
  assign oob      = |oob_v;
  assign cur_addr = {cur_q[2][CW+1:2], cur_q[1][CW+1:2], cur_q[0][CW+1:2]};
  assign cur_bit  = {cur_q[2][1:0], cur_q[1][1:0], cur_q[0][1:0]};
  assign occupied = in_grid && ram_rdata[WORD_W] && ram_rdata[cur_bit];

  // Map address of a voxel write
  assign wxe     = {2'b00, wx_q};
  assign wye     = {2'b00, wy_q};
  assign wze     = {2'b00, wz_q};
  assign wch[0]  = wxe[CW+1:2];
  assign wch[1]  = wye[CW+1:2];
  assign wch[2]  = wze[CW+1:2];
  assign wr_addr = {wch[2], wch[1], wch[0]};
  assign wr_bit  = {wz_q[1:0], wy_q[1:0], wx_q[1:0]};
  assign old_word = ram_rdata[WORD_W] ? ram_rdata[WORD_W-1:0] : '0;
  assign wr_mask  = WORD_W'(1) << wr_bit;
  assign new_word = won_q ? (old_word | wr_mask) : (old_word & ~wr_mask);

  // RAM port
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {1'b1, new_word};
    ram_addr  = cur_addr;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = clr_q;
      end
      S_WR_RD: ram_addr = wr_addr;
      S_WR_WB: begin
        ram_we   = 1'b1;
        ram_addr = wr_addr;
      end
      default: ;
    endcase
  end

  vrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Axis of the earliest crossing, ties to the lower axis
  assign m01   = (tmax_q[1] < tmax_q[0]) ? 2'd1 : 2'd0;
  assign m_sel = (tmax_q[2] < tmax_q[m01]) ? 2'd2 : m01;

  // Hit position from the registered product, saturated
  assign mag    = arsp.res[P_W-1:F];
  assign o_wide = SW'(org_ax);
  assign m_wide = $signed({2'b00, mag});
  assign p_wide = neg_q[ax_q] ? (o_wide - m_wide) : (o_wide + m_wide);
  always_comb begin
    if (p_wide > SW'(vrt_pkg::POS_MAX)) begin
      p_sat = vrt_pkg::POS_MAX;
    end else if (p_wide < SW'(vrt_pkg::POS_MIN)) begin
      p_sat = vrt_pkg::POS_MIN;
    end else begin
      p_sat = p_wide[POS_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:      if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (start_i) begin
          case (func_i)
            vrt_pkg::FUNC_WRITE: begin
              if ((9'(vox_x_i) < WR_LIM) && (9'(vox_y_i) < WR_LIM) &&
                  (9'(vox_z_i) < WR_LIM)) begin
                state_d = S_WR_RD;
              end
            end
            vrt_pkg::FUNC_CLEAR: state_d = S_CLR;
            vrt_pkg::FUNC_CAST:  state_d = S_SET;
            default: ;
          endcase
        end
      end
      S_WR_RD:    state_d = S_WR_WB;
      S_WR_WB:    state_d = S_IDLE;
      S_SET: begin
        if (ad_ax != '0) begin
          state_d = S_DIV_DEL;
        end else if (last_ax) begin
          state_d = all_zero ? S_DONE : S_STEP_RD;
        end
      end
      S_DIV_DEL:  if (arsp.done) state_d = S_DIV_TM;
      S_DIV_TM: begin
        if (arsp.done) state_d = last_ax ? S_STEP_RD : S_SET;
      end
      S_STEP_RD:  state_d = S_STEP_CHK;
      S_STEP_CHK: begin
        if (occupied) begin
          state_d = S_MUL_GO;
        end else begin
          state_d = box_ne_q ? S_EXIT : S_DONE;
        end
      end
      S_EXIT:     state_d = oob ? S_DONE : S_STEP_RD;
      S_MUL_GO:   state_d = S_MUL_W;
      S_MUL_W: begin
        if (arsp.done) state_d = last_ax ? S_DONE : S_MUL_GO;
      end
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Control registers: state, sweep counter, axis counter, box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      ax_q     <= '0;
      box_ne_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= BOX_TOP;
        bmax_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept && (func_i == vrt_pkg::FUNC_CLEAR)) begin
        clr_q    <= '0;
        box_ne_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          bmin_q[i] <= BOX_TOP;
          bmax_q[i] <= '0;
        end
      end
      if (state_q == S_WR_WB) begin
        box_ne_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!box_ne_q || (wch[i] < bmin_q[i])) bmin_q[i] <= wch[i];
          if (!box_ne_q || (wch[i] > bmax_q[i])) bmax_q[i] <= wch[i];
        end
      end
      // advance the axis through setup and multiply passes
      if (accept) begin
        ax_q <= '0;
      end else if (((state_q == S_SET) && (ad_ax == '0)) ||
                   ((state_q == S_DIV_TM) && arsp.done) ||
                   ((state_q == S_MUL_W) && arsp.done)) begin
        ax_q <= last_ax ? 2'd0 : ax_q + 1'b1;
      end else if ((state_q == S_STEP_CHK) && occupied) begin
        ax_q <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wx_q  <= vox_x_i;
      wy_q  <= vox_y_i;
      wz_q  <= vox_z_i;
      won_q <= vox_on_i;
      org_q[0] <= origin_x_i;
      org_q[1] <= origin_y_i;
      org_q[2] <= origin_z_i;
      neg_q    <= {dir_z_i[DIR_W-1], dir_y_i[DIR_W-1], dir_x_i[DIR_W-1]};
      ad_q[0]  <= dir_x_i[DIR_W-1] ? AD_W'(-dir_x_i) : AD_W'(dir_x_i);
      ad_q[1]  <= dir_y_i[DIR_W-1] ? AD_W'(-dir_y_i) : AD_W'(dir_y_i);
      ad_q[2]  <= dir_z_i[DIR_W-1] ? AD_W'(-dir_z_i) : AD_W'(dir_z_i);
      cur_q[0]  <= CUR_W'($signed(origin_x_i[POS_W-1:F]));
      cur_q[1]  <= CUR_W'($signed(origin_y_i[POS_W-1:F]));
      cur_q[2]  <= CUR_W'($signed(origin_z_i[POS_W-1:F]));
      open_q[0] <= CUR_W'($signed(origin_x_i[POS_W-1:F]));
      open_q[1] <= CUR_W'($signed(origin_y_i[POS_W-1:F]));
      open_q[2] <= CUR_W'($signed(origin_z_i[POS_W-1:F]));
      t_q   <= '0;
      hit_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
      end
    end
    unique case (state_q)
      S_SET: begin
        if (ad_ax == '0) begin
          tmax_q[ax_q]  <= '1;
          delta_q[ax_q] <= '0;
        end
      end
      S_DIV_DEL: if (arsp.done) delta_q[ax_q] <= arsp.res[DELTA_W-1:0];
      S_DIV_TM:  if (arsp.done) tmax_q[ax_q] <= T_W'(arsp.res[NUM_W-1:0]);
      S_STEP_RD: m_q <= m_sel;
      S_STEP_CHK: begin
        if (occupied) begin
          hit_q <= 1'b1;
        end else begin
          // record the empty voxel, then step across the nearest face
          for (int i = 0; i < 3; i++) begin
            open_q[i] <= cur_q[i];
          end
          cur_q[m_q]  <= neg_q[m_q] ? (cur_q[m_q] - 1'b1) : (cur_q[m_q] + 1'b1);
          t_q         <= tmax_q[m_q];
          tmax_q[m_q] <= tmax_q[m_q] + T_W'(delta_q[m_q]);
        end
      end
      S_MUL_W: if (arsp.done) pos_q[ax_q] <= p_sat;
      default: ;
    endcase
  end

  // Result ports
  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign hit_o    = hit_q;
  assign hit_x_o  = pos_q[0];
  assign hit_y_o  = pos_q[1];
  assign hit_z_o  = pos_q[2];
  assign open_x_o = open_q[0][OPEN_W-1:0];
  assign open_y_o = open_q[1][OPEN_W-1:0];
  assign open_z_o = open_q[2][OPEN_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/vrt_checker.sv =====
// Port-level checks of the voxel ray traversal core, bound to the top level.
`default_nettype none

module vrt_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start_i,
  input wire logic                             busy_o,
  input wire logic [1:0]                       func_i,
  input wire logic                             done_o,
  input wire logic                             hit_o,
  input wire logic signed [vrt_pkg::POS_W-1:0] hit_x_o,
  input wire logic signed [vrt_pkg::POS_W-1:0] hit_y_o,
  input wire logic signed [vrt_pkg::POS_W-1:0] hit_z_o
);

  // A result word only appears while a command is in hand
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  // The result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // A taken command with a valid code makes the core busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i != vrt_pkg::FUNC_NONE)) |=> busy_o)
    else $error("command taken but core not busy");

  // A miss reports the zero position
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> ((hit_x_o == '0) && (hit_y_o == '0) && (hit_z_o == '0)))
    else $error("miss with nonzero position");

endmodule

bind voxel_ray_traversal_core vrt_checker u_vrt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .func_i  (func_i),
  .done_o  (done_o),
  .hit_o   (hit_o),
  .hit_x_o (hit_x_o),
  .hit_y_o (hit_y_o),
  .hit_z_o (hit_z_o)
);

`default_nettype wire

// ===== tb/voxel_ray_traversal_core_test.sv =====
// Testbench for the voxel ray traversal core: map writes, clears and ray casts.
`timescale 1ns / 100ps

module voxel_ray_traversal_core_test;
  import vrt_pkg::*;

  localparam int  GRID    = GRID_CHUNKS_DEF;
  localparam int  VOXMAX  = 4 * GRID;
  localparam int  NCHUNK  = GRID * GRID * GRID;
  localparam longint CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic                    hit;
    logic [POS_W-1:0]        hx;
    logic [POS_W-1:0]        hy;
    logic [POS_W-1:0]        hz;
    logic [OPEN_W-1:0]       ox;
    logic [OPEN_W-1:0]       oy;
    logic [OPEN_W-1:0]       oz;
  } ray_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = FUNC_NONE;
  logic [VOX_W-1:0] vox_x_i = '0, vox_y_i = '0, vox_z_i = '0;
  logic vox_on_i = 1'b0;
  logic signed [POS_W-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [DIR_W-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic done_o, hit_o;
  logic signed [POS_W-1:0] hit_x_o, hit_y_o, hit_z_o;
  logic signed [OPEN_W-1:0] open_x_o, open_y_o, open_z_o;

  voxel_ray_traversal_core uut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow map of the occupancy grid and touched-chunk box
  logic [63:0] occ_words [NCHUNK];
  bit          occ_touched [NCHUNK];
  longint      box_lo [3];
  longint      box_hi [3];
  bit          box_used;

  ray_word_t   pending_rays [$];
  int          error_count = 0;
  longint      cycle_count = 0;
  bit          quiet = 1'b0;
  int          items_sent = 0;

  function automatic void map_reset();
    for (int c = 0; c < NCHUNK; c++) begin
      occ_words[c] = '0;
      occ_touched[c] = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = GRID - 1;
      box_hi[i] = 0;
    end
    box_used = 1'b0;
  endfunction

  function automatic int chunk_slot(longint x, longint y, longint z);
    return int'(((z >> 2) * GRID + (y >> 2)) * GRID + (x >> 2));
  endfunction

  function automatic void map_write(longint x, longint y, longint z, bit on);
    int c;
    longint v [3];
    v[0] = x; v[1] = y; v[2] = z;
    if (x >= VOXMAX || y >= VOXMAX || z >= VOXMAX) return;
    c = chunk_slot(x, y, z);
    if (!occ_touched[c]) begin
      occ_touched[c] = 1'b1;
      occ_words[c] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      if (!box_used || (v[i] >> 2) < box_lo[i]) box_lo[i] = v[i] >> 2;
      if (!box_used || (v[i] >> 2) > box_hi[i]) box_hi[i] = v[i] >> 2;
    end
    box_used = 1'b1;
    occ_words[c][(z & 3) * 16 + (y & 3) * 4 + (x & 3)] = on;
  endfunction

  function automatic bit occupied(longint v [3]);
    int c;
    for (int i = 0; i < 3; i++)
      if (v[i] < 0 || v[i] >= VOXMAX) return 1'b0;
    c = chunk_slot(v[0], v[1], v[2]);
    if (!occ_touched[c]) return 1'b0;
    return occ_words[c][(v[2] & 3) * 16 + (v[1] & 3) * 4 + (v[0] & 3)];
  endfunction

  // Walk the ray in grid DDA and form the result word
  function automatic ray_word_t trace_ray(longint o [3], longint d [3]);
    ray_word_t r;
    longint cur [3], open [3], lo [3], hi [3], p;
    int stp [3];
    longint unsigned ad [3], delta [3], tmax [3], t, frac, face_gap, mag;
    int m;
    bit hit, gone;
    t = 0;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cur[i] = o[i] >>> FRAC_BITS;
      frac = longint'(o[i]) & 64'hFFFF;
      stp[i] = d[i] < 0 ? -1 : 1;
      ad[i] = d[i] < 0 ? -d[i] : d[i];
      if (stp[i] > 0) face_gap = 65536 - frac;
      else face_gap = (frac == 0) ? 65536 : frac;
      if (ad[i] == 0) begin
        delta[i] = '1;
        tmax[i] = '1;
      end else begin
        delta[i] = (64'd1 << (2 * FRAC_BITS)) / ad[i];
        tmax[i] = (face_gap << FRAC_BITS) / ad[i];
      end
      lo[i] = box_lo[i] * 4;
      hi[i] = box_hi[i] * 4 + 3;
      open[i] = cur[i];
    end
    if (ad[0] != 0 || ad[1] != 0 || ad[2] != 0) begin
      while (1) begin
        gone = 1'b0;
        if (occupied(cur)) begin
          hit = 1'b1;
          break;
        end
        for (int i = 0; i < 3; i++) open[i] = cur[i];
        m = 0;
        if (tmax[1] < tmax[0]) m = 1;
        if (tmax[2] < tmax[m]) m = 2;
        cur[m] += stp[m];
        t = tmax[m];
        tmax[m] += delta[m];
        if (!box_used) break;
        for (int i = 0; i < 3; i++)
          if (stp[i] > 0 ? cur[i] > hi[i] : cur[i] < lo[i]) gone = 1'b1;
        if (gone) break;
      end
    end
    r.hit = hit;
    for (int i = 0; i < 3; i++) begin
      p = 0;
      if (hit) begin
        if (ad[i] != 0 && t > 64'hFFFF_FFFF_FFFF_FFFF / ad[i]) mag = '1;
        else mag = t * ad[i];
        mag = mag >> FRAC_BITS;
        if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
        p = o[i] + (d[i] < 0 ? -longint'(mag) : longint'(mag));
        if (p > 8388607) p = 8388607;
        if (p < -8388608) p = -8388608;
      end
      case (i)
        0: begin r.hx = p[POS_W-1:0]; r.ox = open[i][OPEN_W-1:0]; end
        1: begin r.hy = p[POS_W-1:0]; r.oy = open[i][OPEN_W-1:0]; end
        default: begin r.hz = p[POS_W-1:0]; r.oz = open[i][OPEN_W-1:0]; end
      endcase
    end
    return r;
  endfunction

  // Drive one command word and predict its effect once taken
  task automatic send_word(logic [1:0] f, int x, int y, int z, bit on,
                           int ox, int oy, int oz, int dx, int dy, int dz);
    longint o [3], d [3];
    if (!quiet && $urandom_range(0, 99) < 6)
      repeat ($urandom_range(1, 6)) @(negedge clk_i) start_i = 1'b0;
    @(negedge clk_i);
    start_i = 1'b1;
    func_i = f;
    vox_x_i = VOX_W'(x); vox_y_i = VOX_W'(y); vox_z_i = VOX_W'(z); vox_on_i = on;
    origin_x_i = POS_W'(ox); origin_y_i = POS_W'(oy); origin_z_i = POS_W'(oz);
    dir_x_i = DIR_W'(dx); dir_y_i = DIR_W'(dy); dir_z_i = DIR_W'(dz);
    do @(posedge clk_i); while (busy_o);
    case (f)
      FUNC_WRITE: map_write(vox_x_i, vox_y_i, vox_z_i, on);
      FUNC_CLEAR: map_reset();
      FUNC_CAST: begin
        o[0] = origin_x_i; o[1] = origin_y_i; o[2] = origin_z_i;
        d[0] = dir_x_i; d[1] = dir_y_i; d[2] = dir_z_i;
        pending_rays.push_back(trace_ray(o, d));
      end
      default: ;
    endcase
    items_sent++;
    @(negedge clk_i) start_i = 1'b0;
  endtask

  task automatic put_voxel(int x, int y, int z, bit on);
    send_word(FUNC_WRITE, x, y, z, on, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  task automatic cast_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    send_word(FUNC_CAST, $urandom, $urandom, $urandom, $urandom, ox, oy, oz, dx, dy, dz);
  endtask

  task automatic clear_map();
    send_word(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_rays.size() != 0) @(posedge clk_i);
  endtask

  function automatic int rand_dir();
    int mag;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65536;
      2: return -65536;
      default: begin
        mag = $urandom_range(0, 65536);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic int rand_origin();
    case ($urandom_range(0, 9))
      0: return int'({{8{$urandom_range(0, 1) == 1}}, 24'($urandom)}) >>> 0;
      1: return -int'($urandom_range(0, 16 << 16));
      default: return $urandom_range(0, VOXMAX << 16);
    endcase
  endfunction

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    ray_word_t exp_w;
    if (rst_ni && done_o) begin
      if (pending_rays.size() == 0) begin
        $error("result with no cast outstanding");
        error_count++;
      end else begin
        exp_w = pending_rays.pop_front();
        if (hit_o !== exp_w.hit) begin
          $error("hit: expected %0d, got %0d", exp_w.hit, hit_o); error_count++;
        end
        if (hit_x_o !== exp_w.hx) begin
          $error("hit_x: expected %0h, got %0h", exp_w.hx, hit_x_o); error_count++;
        end
        if (hit_y_o !== exp_w.hy) begin
          $error("hit_y: expected %0h, got %0h", exp_w.hy, hit_y_o); error_count++;
        end
        if (hit_z_o !== exp_w.hz) begin
          $error("hit_z: expected %0h, got %0h", exp_w.hz, hit_z_o); error_count++;
        end
        if (open_x_o !== exp_w.ox) begin
          $error("open_x: expected %0h, got %0h", exp_w.ox, open_x_o); error_count++;
        end
        if (open_y_o !== exp_w.oy) begin
          $error("open_y: expected %0h, got %0h", exp_w.oy, open_y_o); error_count++;
        end
        if (open_z_o !== exp_w.oz) begin
          $error("open_z: expected %0h, got %0h", exp_w.oz, open_z_o); error_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    cast_ray(5 << 16, 5 << 16, 5 << 16, 65536, 0, 0);          // empty map
    cast_ray(3 << 16, 7 << 16, 9 << 16, 0, 0, 0);              // zero direction
    cast_ray(-8388608, 8388607, 0, 0, 0, 0);
    put_voxel(0, 0, 0, 1'b1);
    put_voxel(63, 63, 63, 1'b1);
    put_voxel(20, 0, 0, 1'b1);
    put_voxel(20, 0, 0, 1'b0);                                  // clear a voxel
    put_voxel(30, 0, 0, 1'b1);
    send_word(FUNC_NONE, 5, 5, 5, 1'b1, 0, 0, 0, 1, 1, 1);      // ignored code
    cast_ray(32'h8000, 32'h8000, 32'h8000, 65536, 0, 0);        // starts on occupied
    cast_ray(5 << 16, 32'h8000, 32'h8000, 65536, 0, 0);         // runs into x=30
    cast_ray(60 << 16, 63 << 16, 63 << 16, 65536, 0, 0);
    cast_ray(40 << 16, 32'h8000, 32'h8000, -65536, 0, 0);       // on a face, step back
    cast_ray(60 << 16, 60 << 16, 60 << 16, 65536, 65536, 65536); // diagonal tie
    cast_ray(-8388608, -8388608, -8388608, 65536, 65536, 65536);
    cast_ray(8388607, 8388607, 8388607, -65536, -65536, -65536);
    cast_ray(10 << 16, 10 << 16, 10 << 16, 1, -1, 0);            // tiny steps
    cast_ray(70 << 16, 63 << 16, 63 << 16, -131071, 0, 0);
    wait_drained();
    clear_map();
    cast_ray(0, 0, 0, 65536, 0, 0);
  endtask

  task automatic test_scene_casts(int target);
    int nw, cx, cy, cz, span;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) wait_drained();
      clear_map();
      span = $urandom_range(0, 1) ? 63 : $urandom_range(2, 20);
      cx = $urandom_range(0, 63 - (span > 62 ? 63 : span));
      cy = $urandom_range(0, 63 - (span > 62 ? 63 : span));
      cz = $urandom_range(0, 63 - (span > 62 ? 63 : span));
      nw = $urandom_range(1, 50);
      repeat (nw) put_voxel(cx + $urandom_range(0, span > 62 ? 0 : span),
                            cy + $urandom_range(0, span > 62 ? 0 : span),
                            cz + $urandom_range(0, span > 62 ? 0 : span),
                            $urandom_range(0, 7) != 0);
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(0, 15))
          0: send_word(FUNC_NONE, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          1: put_voxel($urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 63), $urandom_range(0, 1));
          default: cast_ray(rand_origin(), rand_origin(), rand_origin(),
                            rand_dir(), rand_dir(), rand_dir());
        endcase
      end
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    put_voxel(32, 32, 32, 1'b1);
    repeat (40) cast_ray($urandom_range(0, 63 << 16), 32 << 16, 32 << 16,
                         rand_dir(), rand_dir(), rand_dir());
    quiet = 1'b0;
  endtask

  initial begin
    map_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_directed();
    test_scene_casts(400);
    test_back_to_back();
    wait_drained();
    test_scene_casts(960);
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vrt_pkg.sv
hw/rtl/vrt_ram.sv
hw/rtl/vrt_arith.sv
hw/rtl/voxel_ray_traversal_core.sv
hw/rtl/vrt_checker.sv
tb/voxel_ray_traversal_core_test.sv
